// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by i2cm_seq and i2c_master_bit_engine.
package i2cm_pkg;

   localparam int WAIT_WIDTH = 16;
   localparam logic [WAIT_WIDTH-1:0] WAIT_RESET = WAIT_WIDTH'(250);
   localparam logic [3:0] BYTE_BITS = 4'd8;

   localparam logic [2:0] OP_START  = 3'd0;
   localparam logic [2:0] OP_STOP   = 3'd1;
   localparam logic [2:0] OP_WRITE  = 3'd2;
   localparam logic [2:0] OP_RD_ACK = 3'd3;
   localparam logic [2:0] OP_RD_NAK = 3'd4;

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_ST_A = 4'd1,
      PH_ST_B = 4'd2,
      PH_SP_A = 4'd3,
      PH_SP_B = 4'd4,
      PH_SP_C = 4'd5,
      PH_WB   = 4'd6,
      PH_WH   = 4'd7,
      PH_WL   = 4'd8,
      PH_WA   = 4'd9,
      PH_WAH  = 4'd10,
      PH_RP   = 4'd11,
      PH_RH   = 4'd12,
      PH_RA   = 4'd13,
      PH_RAH  = 4'd14
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] op;
      logic [7:0] tx_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_bit;
   } rsp_type;

endpackage

// ===== rtl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: handshake, wait register, result register.
// Depends on i2cm_pkg and i2cm_seq.

// Each request transfer is one time tick: it carries the sampled SDA level and
// optionally a command (start, stop, write byte, read byte with ACK or NAK).
// The engine advances its bus sequence by exactly one tick per request and
// returns one response per request, holding the SCL/SDA levels and status
// after that tick. A request is taken every clock cycle; its response appears
// in the result register on the following cycle. While the response side
// stalls with a response pending, the request side is stalled too. Every pause
// between line changes lasts csr_wr_data ticks as last written (reset 250;
// zero counts as one tick). Commands offered while busy are dropped.
module i2c_master_bit_engine
   import i2cm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [WAIT_WIDTH-1:0] csr_wr_data
);

   logic [WAIT_WIDTH-1:0] wait_ticks_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               seq_rsp;
   logic                  step;

   // hold input only while a response waits on a stalled consumer
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign step         = req_valid & ~req_stall;
   assign rsp_valid_in = step | (rsp_valid_ff & rsp_stall);

   i2cm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .req        (req_data),
      .wait_ticks (wait_ticks_ff),
      .rsp        (seq_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ticks_ff <= WAIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            wait_ticks_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= seq_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/i2cm_seq.sv =====
// Tick sequencer of the I2C master: phase machine, pause counter, shifter.
// Depends on i2cm_pkg; instantiated by i2c_master_bit_engine.
module i2cm_seq
   import i2cm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  req_type               req,
   input  logic [WAIT_WIDTH-1:0] wait_ticks,
   output rsp_type               rsp
);

   phase_type             phase_ff, phase_in;
   logic [2:0]            op_ff, op_in;
   logic [3:0]            bit_ff, bit_in;
   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            received_ff, received_in;
   logic                  ack_ff, ack_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  drv_ff, drv_in;
   logic                  done;
   logic [WAIT_WIDTH-1:0] pause;
   logic [WAIT_WIDTH-1:0] count_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         op_ff       <= OP_START;
         bit_ff      <= '0;
         wait_ff     <= '0;
         shift_ff    <= '0;
         received_ff <= '0;
         ack_ff      <= 1'b1;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         drv_ff      <= 1'b1;
      end else begin
         phase_ff    <= phase_in;
         op_ff       <= op_in;
         bit_ff      <= bit_in;
         wait_ff     <= wait_in;
         shift_ff    <= shift_in;
         received_ff <= received_in;
         ack_ff      <= ack_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
         drv_ff      <= drv_in;
      end
   end

   // a zero pause setting still lasts one tick
   assign pause     = (wait_ticks == '0) ? WAIT_WIDTH'(1) : wait_ticks;
   assign count_dec = wait_ff - WAIT_WIDTH'(wait_ff != '0);

   always_comb begin
      phase_in    = phase_ff;
      op_in       = op_ff;
      bit_in      = bit_ff;
      wait_in     = wait_ff;
      shift_in    = shift_ff;
      received_in = received_ff;
      ack_in      = ack_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      drv_in      = drv_ff;
      done        = 1'b0;

      if (step) begin
         if (phase_ff == PH_IDLE) begin
            if (req.cmd_valid && (req.op inside {[OP_START:OP_RD_NAK]})) begin
               op_in   = req.op;
               bit_in  = '0;
               wait_in = pause;
               case (req.op)
                  OP_START: begin
                     drv_in   = 1'b1;
                     sda_in   = 1'b1;
                     scl_in   = 1'b1;
                     phase_in = PH_ST_A;
                  end
                  OP_STOP: begin
                     drv_in   = 1'b1;
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     phase_in = PH_SP_A;
                  end
                  OP_WRITE: begin
                     drv_in   = 1'b1;
                     sda_in   = req.tx_byte[7];
                     shift_in = {req.tx_byte[6:0], 1'b0};
                     phase_in = PH_WB;
                  end
                  default: begin
                     // both read commands: clear accumulator, release SDA
                     shift_in = '0;
                     drv_in   = 1'b0;
                     phase_in = PH_RP;
                  end
               endcase
            end
         end else begin
            wait_in = count_dec;
            if (count_dec == '0) begin
               phase_in = PH_IDLE;
               case (phase_ff)
                  PH_ST_A: begin
                     sda_in   = 1'b0;
                     phase_in = PH_ST_B;
                  end
                  PH_ST_B: begin
                     scl_in = 1'b0;
                     done   = 1'b1;
                  end
                  PH_SP_A: begin
                     scl_in   = 1'b1;
                     phase_in = PH_SP_B;
                  end
                  PH_SP_B: begin
                     sda_in   = 1'b1;
                     drv_in   = 1'b1;
                     phase_in = PH_SP_C;
                  end
                  PH_SP_C: done = 1'b1;
                  PH_WB: begin
                     scl_in   = 1'b1;
                     phase_in = PH_WH;
                  end
                  PH_WH: begin
                     scl_in   = 1'b0;
                     phase_in = PH_WL;
                  end
                  PH_WL: begin
                     bit_in = bit_ff + 4'd1;
                     if (bit_in < BYTE_BITS) begin
                        drv_in   = 1'b1;
                        sda_in   = shift_ff[7];
                        shift_in = {shift_ff[6:0], 1'b0};
                        phase_in = PH_WB;
                     end else begin
                        drv_in   = 1'b0;
                        phase_in = PH_WA;
                     end
                  end
                  PH_WA: begin
                     scl_in   = 1'b1;
                     ack_in   = req.sda_in;
                     phase_in = PH_WAH;
                  end
                  PH_WAH: begin
                     scl_in = 1'b0;
                     done   = 1'b1;
                  end
                  PH_RP: begin
                     // sample on the rising SCL tick itself
                     scl_in   = 1'b1;
                     shift_in = {shift_ff[6:0], req.sda_in};
                     phase_in = PH_RH;
                  end
                  PH_RH: begin
                     scl_in = 1'b0;
                     bit_in = bit_ff + 4'd1;
                     if (bit_in < BYTE_BITS) begin
                        phase_in = PH_RP;
                     end else begin
                        drv_in   = 1'b1;
                        sda_in   = (op_ff == OP_RD_NAK);
                        phase_in = PH_RA;
                     end
                  end
                  PH_RA: begin
                     scl_in   = 1'b1;
                     phase_in = PH_RAH;
                  end
                  PH_RAH: begin
                     scl_in      = 1'b0;
                     received_in = shift_ff;
                     done        = 1'b1;
                  end
                  default: phase_in = PH_IDLE;
               endcase
               if (phase_in != PH_IDLE) begin
                  wait_in = pause;
               end
            end
         end
      end
   end

   always_comb begin
      rsp.scl_level = scl_in;
      rsp.sda_level = drv_in & sda_in;
      rsp.sda_drive = drv_in;
      rsp.busy_res  = (phase_in != PH_IDLE);
      rsp.done_res  = done;
      rsp.rx_byte   = received_in;
      rsp.ack_bit   = ack_in;
   end

endmodule
